>>> hw/rtl/tfa_pkg.sv
// ----------------------------------------------------------------------------
// tfa_pkg
// Shared widths, register indexes, types and helpers of the texel fetch
// addresser.
// ----------------------------------------------------------------------------
package tfa_pkg;

  localparam int MAX_DIM   = 2048;
  localparam int FRAC_BITS = 16;
  localparam int POS_W     = $clog2(MAX_DIM);        // texel row/column
  localparam int DIM_W     = POS_W + 1;              // dimension up to MAX_DIM
  localparam int ACC_W     = DIM_W + FRAC_BITS;      // fixed-point accumulator
  localparam int DVD_W     = POS_W + FRAC_BITS;      // step dividend
  localparam int IDX_W     = 22;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = DIM_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE       = 4'd0,
    REG_ROW_STRIDE = 4'd1,
    REG_REGION_X   = 4'd2,
    REG_REGION_Y   = 4'd3,
    REG_REGION_W   = 4'd4,
    REG_REGION_H   = 4'd5,
    REG_TEX_W      = 4'd6,
    REG_TEX_H      = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic             mode;
    logic [DIM_W-1:0] row_stride;
    logic [POS_W-1:0] region_x;
    logic [POS_W-1:0] region_y;
    logic [DIM_W-1:0] region_w;
    logic [DIM_W-1:0] region_h;
    logic [DIM_W-1:0] tex_w;
    logic [DIM_W-1:0] tex_h;
  } cfg_t;

  // source coordinates of one texel, handed from the walker to the index stage
  typedef struct packed {
    logic [DIM_W-1:0] srow;
    logic [DIM_W-1:0] scol;
    logic             pad;
    logic             last;
  } coord_t;

  // zero reads as 1, anything above MAX_DIM as MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/tfa_div.sv
// ----------------------------------------------------------------------------
// tfa_div
// Restoring divider, one quotient bit per cycle, for the fixed-point steps.
// ----------------------------------------------------------------------------
module tfa_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [tfa_pkg::DVD_W-1:0]     dividend,
  input  logic [tfa_pkg::DIM_W-1:0]     divisor,
  output logic                          busy,
  output logic [tfa_pkg::ACC_W-1:0]     quotient
);

  localparam int CNT_W = $clog2(tfa_pkg::DVD_W + 1);

  logic [CNT_W-1:0]          cnt;
  logic [tfa_pkg::DVD_W-1:0] dvd;
  logic [tfa_pkg::DIM_W-1:0] dvs;
  logic [tfa_pkg::DIM_W-1:0] rem;
  logic [tfa_pkg::DVD_W-1:0] quo;

  logic [tfa_pkg::DIM_W:0]   rem_sh;
  logic                      ge;
  logic [tfa_pkg::DIM_W:0]   rem_sub;

  assign rem_sh  = {rem, dvd[tfa_pkg::DVD_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs};
  assign rem_sub = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      quo <= '0;
    end else if (start) begin
      cnt <= CNT_W'(tfa_pkg::DVD_W);
      quo <= '0;
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (cnt != '0) begin
      cnt <= cnt - CNT_W'(1);
      dvd <= {dvd[tfa_pkg::DVD_W-2:0], 1'b0};
      // remainder stays below the divisor, so it fits DIM_W bits
      rem <= ge ? rem_sub[tfa_pkg::DIM_W-1:0] : rem_sh[tfa_pkg::DIM_W-1:0];
      quo <= {quo[tfa_pkg::DVD_W-2:0], ge};
    end
  end

  assign busy     = cnt != '0;
  assign quotient = tfa_pkg::ACC_W'(quo);

endmodule

>>> hw/rtl/tfa_walk.sv
// ----------------------------------------------------------------------------
// tfa_walk
// Raster walker: keeps the texel position and DDA accumulators and registers
// the source coordinates of each accepted texel.
// ----------------------------------------------------------------------------
module tfa_walk (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic                      restart,
  input  tfa_pkg::cfg_t             cfg,
  input  logic [tfa_pkg::ACC_W-1:0] u_step,
  input  logic [tfa_pkg::ACC_W-1:0] v_step,
  output tfa_pkg::coord_t           coord
);

  localparam int POS_W = tfa_pkg::POS_W;
  localparam int DIM_W = tfa_pkg::DIM_W;
  localparam int ACC_W = tfa_pkg::ACC_W;
  localparam int FRAC_BITS = tfa_pkg::FRAC_BITS;

  logic [POS_W-1:0] out_row;
  logic [POS_W-1:0] out_col;
  logic [ACC_W-1:0] u_accum;
  logic [ACC_W-1:0] v_accum;

  logic [POS_W-1:0] out_row_next;
  logic [POS_W-1:0] out_col_next;
  logic [ACC_W-1:0] u_accum_next;
  logic [ACC_W-1:0] v_accum_next;
  tfa_pkg::coord_t  coord_next;

  logic [DIM_W-1:0] tw, th, rw, rh;
  logic             wrap;
  logic [POS_W-1:0] row0, col0;
  logic [ACC_W-1:0] u0, v0;
  logic [DIM_W-1:0] col_inc, row_inc;

  always_comb begin
    tw = tfa_pkg::clamp_dim(cfg.tex_w);
    th = tfa_pkg::clamp_dim(cfg.tex_h);
    rw = tfa_pkg::clamp_dim(cfg.region_w);
    rh = tfa_pkg::clamp_dim(cfg.region_h);

    // a position left outside a shrunken texture starts a new pass
    wrap = restart || ({1'b0, out_row} >= th) || ({1'b0, out_col} >= tw);
    row0 = wrap ? '0 : out_row;
    col0 = wrap ? '0 : out_col;
    u0   = (wrap || col0 == '0) ? '0 : u_accum;
    v0   = wrap ? '0 : v_accum;

    if (cfg.mode) begin
      coord_next.srow = v0[ACC_W-1:FRAC_BITS];
      coord_next.scol = u0[ACC_W-1:FRAC_BITS];
      coord_next.pad  = 1'b0;
    end else begin
      coord_next.srow = {1'b0, row0} + {1'b0, cfg.region_y};
      coord_next.scol = {1'b0, col0} + {1'b0, cfg.region_x};
      coord_next.pad  = ({1'b0, row0} >= rh) || ({1'b0, col0} >= rw);
    end
    coord_next.last = ({1'b0, row0} == th - DIM_W'(1)) &&
                      ({1'b0, col0} == tw - DIM_W'(1));

    col_inc = {1'b0, col0} + DIM_W'(1);
    row_inc = {1'b0, row0} + DIM_W'(1);
    out_row_next = row0;
    v_accum_next = v0;
    if (col_inc < tw) begin
      out_col_next = col_inc[POS_W-1:0];
      u_accum_next = u0 + u_step;
    end else begin
      out_col_next = '0;
      u_accum_next = '0;
      if (row_inc < th) begin
        out_row_next = row_inc[POS_W-1:0];
        v_accum_next = v0 + v_step;
      end else begin
        out_row_next = '0;
        v_accum_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_row <= '0;
      out_col <= '0;
      u_accum <= '0;
      v_accum <= '0;
    end else if (accept) begin
      out_row <= out_row_next;
      out_col <= out_col_next;
      u_accum <= u_accum_next;
      v_accum <= v_accum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      coord <= coord_next;
    end
  end

endmodule

>>> hw/rtl/tfa_index.sv
// ----------------------------------------------------------------------------
// tfa_index
// Index stage: row * stride + column into the result register.
// ----------------------------------------------------------------------------
module tfa_index (
  input  logic                      clk,
  input  logic                      load,
  input  tfa_pkg::coord_t           coord,
  input  logic [tfa_pkg::DIM_W-1:0] row_stride,
  output logic [tfa_pkg::IDX_W-1:0] src_index,
  output logic                      pad,
  output logic                      last
);

  localparam int DIM_W  = tfa_pkg::DIM_W;
  localparam int PROD_W = 2 * DIM_W;

  logic [DIM_W-1:0]  stride;
  logic [PROD_W-1:0] prod;
  logic [PROD_W:0]   sum;

  assign stride = tfa_pkg::clamp_dim(row_stride);
  assign prod   = coord.srow * stride;
  assign sum    = {1'b0, prod} + (PROD_W + 1)'(coord.scol);

  always_ff @(posedge clk) begin
    if (load) begin
      src_index <= coord.pad ? '0 : sum[tfa_pkg::IDX_W-1:0];
      pad       <= coord.pad;
      last      <= coord.last;
    end
  end

endmodule

>>> hw/rtl/texture_texel_fetch_addresser.sv
// ----------------------------------------------------------------------------
// texture_texel_fetch_addresser
// Source pixel addresser for texture upload: copy with padding or
// nearest-neighbor scale.
// ----------------------------------------------------------------------------
// One texel address per cycle in raster order while out_ready holds and no
// step division runs; each transfer passes the walker register, then the index
// multiply into the result register. A configuration write recomputes the
// 12.16 scale steps in a bit-serial divider; the input is not ready meanwhile.
// Register writes are expected only while no texel is in flight.
module texture_texel_fetch_addresser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          restart,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tfa_pkg::IDX_W-1:0]     src_index,
  output logic                          pad,
  output logic                          last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tfa_pkg::CFG_DAT_W-1:0] cfg_data
);

  localparam int POS_W = tfa_pkg::POS_W;
  localparam int DIM_W = tfa_pkg::DIM_W;
  localparam int FRAC_BITS = tfa_pkg::FRAC_BITS;

  tfa_pkg::cfg_t             cfg;
  tfa_pkg::coord_t           coord;
  logic                      cfg_we;
  logic                      div_start;
  logic                      u_busy, v_busy, div_busy;
  logic [tfa_pkg::ACC_W-1:0] u_step, v_step;
  logic [DIM_W-1:0]          rw_m1, rh_m1;
  logic                      a_valid;
  logic                      b_space, a_fire, accept;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode       <= 1'b0;
      cfg.row_stride <= DIM_W'(1);
      cfg.region_x   <= '0;
      cfg.region_y   <= '0;
      cfg.region_w   <= DIM_W'(1);
      cfg.region_h   <= DIM_W'(1);
      cfg.tex_w      <= DIM_W'(1);
      cfg.tex_h      <= DIM_W'(1);
      div_start      <= 1'b0;
    end else begin
      div_start <= cfg_we;
      if (cfg_we) begin
        case (tfa_pkg::reg_idx_t'(cfg_index))
          tfa_pkg::REG_MODE:       cfg.mode       <= cfg_data[0];
          tfa_pkg::REG_ROW_STRIDE: cfg.row_stride <= cfg_data;
          tfa_pkg::REG_REGION_X:   cfg.region_x   <= cfg_data[POS_W-1:0];
          tfa_pkg::REG_REGION_Y:   cfg.region_y   <= cfg_data[POS_W-1:0];
          tfa_pkg::REG_REGION_W:   cfg.region_w   <= cfg_data;
          tfa_pkg::REG_REGION_H:   cfg.region_h   <= cfg_data;
          tfa_pkg::REG_TEX_W:      cfg.tex_w      <= cfg_data;
          tfa_pkg::REG_TEX_H:      cfg.tex_h      <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // step = ((dim - 1) << FRAC_BITS) / tex_dim
  assign rw_m1 = tfa_pkg::clamp_dim(cfg.region_w) - DIM_W'(1);
  assign rh_m1 = tfa_pkg::clamp_dim(cfg.region_h) - DIM_W'(1);

  tfa_div u_div_u (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({rw_m1[POS_W-1:0], FRAC_BITS'(0)}),
    .divisor  (tfa_pkg::clamp_dim(cfg.tex_w)),
    .busy     (u_busy),
    .quotient (u_step)
  );

  tfa_div u_div_v (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({rh_m1[POS_W-1:0], FRAC_BITS'(0)}),
    .divisor  (tfa_pkg::clamp_dim(cfg.tex_h)),
    .busy     (v_busy),
    .quotient (v_step)
  );

  assign div_busy = div_start || u_busy || v_busy;

  // two-stage pipe: walker register, then result register
  assign b_space  = !out_valid || out_ready;
  assign a_fire   = a_valid && b_space;
  assign in_ready = !div_busy && (!a_valid || b_space);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        a_valid <= 1'b1;
      end else if (a_fire) begin
        a_valid <= 1'b0;
      end
      if (a_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  tfa_walk u_walk (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .restart (restart),
    .cfg     (cfg),
    .u_step  (u_step),
    .v_step  (v_step),
    .coord   (coord)
  );

  tfa_index u_index (
    .clk        (clk),
    .load       (a_fire),
    .coord      (coord),
    .row_stride (cfg.row_stride),
    .src_index  (src_index),
    .pad        (pad),
    .last       (last)
  );

endmodule
